// ----- rtl/brtd_pkg.sv -----
`timescale 1ns / 1ps

package brtd_pkg;

  // Parser modes. Codes above MODE_STRING are never entered.
  typedef enum logic [2:0] {
    MODE_HEADER = 3'd0,
    MODE_POS    = 3'd1,
    MODE_NEG    = 3'd2,
    MODE_FLOAT  = 3'd3,
    MODE_STRLEN = 3'd4,
    MODE_STRING = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    KIND_INT       = 3'd0,
    KIND_SINGLE    = 3'd1,
    KIND_DOUBLE    = 3'd2,
    KIND_STR_BYTE  = 3'd3,
    KIND_STR_EMPTY = 3'd4
  } kind_t;

  // Type codes in bits 7:6 of a header byte.
  localparam logic [1:0] HDR_POS_INT = 2'd0;
  localparam logic [1:0] HDR_NEG_INT = 2'd1;
  localparam logic [1:0] HDR_FLOAT   = 2'd2;
  localparam logic [1:0] HDR_STRING  = 2'd3;

  localparam int CountWidth = 13;
  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam logic [CountWidth-1:0] SingleLen = 13'd4;
  localparam logic [CountWidth-1:0] DoubleLen = 13'd8;

  typedef struct packed {
    kind_t        kind;
    logic [31:0]  int_value;
    logic [63:0]  float_bits;
    logic         use_exponent;
    logic [3:0]   decimal_places;
    logic [7:0]   string_byte;
    logic         last_of_string;
  } token_t;

endpackage

// ----- rtl/brtd_core.sv -----
`timescale 1ns / 1ps

module brtd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  output logic              emit,
  output brtd_pkg::token_t  token
);

  brtd_pkg::mode_t mode, mode_next;
  logic [31:0] int_accum, int_accum_next;
  logic [12:0] byte_count, byte_count_next;
  logic [12:0] expected_length, expected_length_next;
  logic [63:0] float_accum, float_accum_next;
  logic        float_is_double, float_is_double_next;
  logic        exp_flag, exp_flag_next;
  logic [3:0]  places_count, places_count_next;

  logic [1:0]  hdr_type;
  logic        hdr_cont;
  logic [4:0]  hdr_data;
  logic [31:0] hdr_neg;
  logic [31:0] group_word;
  logic [31:0] int_grouped;
  logic [31:0] int_done;
  logic [12:0] count_sat;
  logic [12:0] count_inc;
  logic [63:0] float_merged;

  assign hdr_type = in_byte[7:6];
  assign hdr_cont = in_byte[5];
  assign hdr_data = in_byte[4:0];
  assign hdr_neg  = 32'd0 - {27'b0, hdr_data};

  // Continuation group k lands at bit 5 + 7k; bits beyond 31 fall off.
  always_comb begin
    case (byte_count[1:0])
      2'd0:    group_word = {20'b0, in_byte[6:0], 5'b0};
      2'd1:    group_word = {13'b0, in_byte[6:0], 12'b0};
      2'd2:    group_word = {6'b0, in_byte[6:0], 19'b0};
      default: group_word = {in_byte[5:0], 26'b0};
    endcase
  end

  assign int_grouped = (byte_count[12:2] == '0) ? (int_accum | group_word) : int_accum;
  assign int_done    = (mode == brtd_pkg::MODE_NEG) ? (32'd0 - int_grouped) : int_grouped;
  assign count_inc   = byte_count + 13'd1;
  assign count_sat   = (byte_count == brtd_pkg::CountMax) ? byte_count : count_inc;
  assign float_merged = float_accum | ({56'b0, in_byte} << {byte_count[2:0], 3'b0});

  always_comb begin
    mode_next            = mode;
    int_accum_next       = int_accum;
    byte_count_next      = byte_count;
    expected_length_next = expected_length;
    float_accum_next     = float_accum;
    float_is_double_next = float_is_double;
    exp_flag_next        = exp_flag;
    places_count_next    = places_count;
    case (mode)
      brtd_pkg::MODE_POS, brtd_pkg::MODE_NEG: begin
        byte_count_next = count_sat;
        int_accum_next  = int_grouped;
        if (!in_byte[7]) begin
          int_accum_next = int_done;
          mode_next      = brtd_pkg::MODE_HEADER;
        end
      end
      brtd_pkg::MODE_FLOAT: begin
        float_accum_next = float_merged;
        byte_count_next  = count_inc;
        if (count_inc == expected_length) begin
          mode_next = brtd_pkg::MODE_HEADER;
        end
      end
      brtd_pkg::MODE_STRLEN: begin
        expected_length_next = expected_length | {in_byte, 5'b0};
        mode_next            = brtd_pkg::MODE_STRING;
      end
      brtd_pkg::MODE_STRING: begin
        byte_count_next = count_inc;
        if (count_inc == expected_length) begin
          mode_next = brtd_pkg::MODE_HEADER;
        end
      end
      default: begin
        // Header byte; unused mode codes also land here.
        mode_next       = brtd_pkg::MODE_HEADER;
        byte_count_next = '0;
        case (hdr_type)
          brtd_pkg::HDR_POS_INT: begin
            int_accum_next = {27'b0, hdr_data};
            if (hdr_cont) begin
              mode_next = brtd_pkg::MODE_POS;
            end
          end
          brtd_pkg::HDR_NEG_INT: begin
            int_accum_next = {27'b0, hdr_data};
            if (hdr_cont) begin
              mode_next = brtd_pkg::MODE_NEG;
            end else begin
              int_accum_next = hdr_neg;
            end
          end
          brtd_pkg::HDR_FLOAT: begin
            float_accum_next     = '0;
            float_is_double_next = hdr_cont;
            expected_length_next = hdr_cont ? brtd_pkg::DoubleLen : brtd_pkg::SingleLen;
            exp_flag_next        = hdr_data[4];
            places_count_next    = hdr_data[3:0];
            mode_next            = brtd_pkg::MODE_FLOAT;
          end
          default: begin
            expected_length_next = {8'b0, hdr_data};
            if (hdr_data != 5'd0) begin
              mode_next = hdr_cont ? brtd_pkg::MODE_STRLEN : brtd_pkg::MODE_STRING;
            end
          end
        endcase
      end
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    token      = '0;
    token.kind = brtd_pkg::KIND_INT;
    case (mode)
      brtd_pkg::MODE_POS, brtd_pkg::MODE_NEG: begin
        if (!in_byte[7]) begin
          emit            = 1'b1;
          token.int_value = int_done;
        end
      end
      brtd_pkg::MODE_FLOAT: begin
        if (count_inc == expected_length) begin
          emit                 = 1'b1;
          token.kind           = float_is_double ? brtd_pkg::KIND_DOUBLE
                                                 : brtd_pkg::KIND_SINGLE;
          token.float_bits     = float_is_double ? float_merged
                                                 : {32'b0, float_merged[31:0]};
          token.use_exponent   = exp_flag;
          token.decimal_places = places_count;
        end
      end
      brtd_pkg::MODE_STRLEN: begin
        // The length extension byte makes no token.
      end
      brtd_pkg::MODE_STRING: begin
        emit              = 1'b1;
        token.kind        = brtd_pkg::KIND_STR_BYTE;
        token.string_byte = in_byte;
        if (count_inc == expected_length) begin
          token.last_of_string = 1'b1;
        end
      end
      default: begin
        case (hdr_type)
          brtd_pkg::HDR_POS_INT: begin
            if (!hdr_cont) begin
              emit            = 1'b1;
              token.int_value = {27'b0, hdr_data};
            end
          end
          brtd_pkg::HDR_NEG_INT: begin
            if (!hdr_cont) begin
              emit            = 1'b1;
              token.int_value = hdr_neg;
            end
          end
          brtd_pkg::HDR_FLOAT: begin
            // A float header only sets up the payload bytes.
          end
          default: begin
            // An empty string reads no extension byte even with continue set.
            if (hdr_data == 5'd0) begin
              emit       = 1'b1;
              token.kind = brtd_pkg::KIND_STR_EMPTY;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= brtd_pkg::MODE_HEADER;
      int_accum       <= '0;
      byte_count      <= '0;
      expected_length <= '0;
      float_accum     <= '0;
      float_is_double <= 1'b0;
      exp_flag        <= 1'b0;
      places_count    <= '0;
    end else if (step) begin
      mode            <= mode_next;
      int_accum       <= int_accum_next;
      byte_count      <= byte_count_next;
      expected_length <= expected_length_next;
      float_accum     <= float_accum_next;
      float_is_double <= float_is_double_next;
      exp_flag        <= exp_flag_next;
      places_count    <= places_count_next;
    end
  end

endmodule

// ----- rtl/binary_record_token_decoder.sv -----
`timescale 1ns / 1ps

// Channel | Handshake             | Payload
// input   | in_valid / in_ready   | in_byte
// output  | out_valid / out_ready | token_kind, int_value, float_bits, use_exponent,
//         |                       | decimal_places, string_byte, last_of_string
//
// One byte is taken every clock cycle while the output is not stalled; the
// parser state update is combinational logic between the input register and
// the token register, which takes a token as the byte completing it moves on.
// Synchronous reset returns the parser to header mode and empties both registers.
// A stalled output holds the token; the input register still accepts a byte
// in the same cycle that its own byte moves on.

module binary_record_token_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         token_kind,
  output logic signed [31:0] int_value,
  output logic [63:0]        float_bits,
  output logic               use_exponent,
  output logic [3:0]         decimal_places,
  output logic [7:0]         string_byte,
  output logic               last_of_string
);

  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             advance;
  logic             emit;
  brtd_pkg::token_t token;
  brtd_pkg::token_t out_token;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= in_byte;
    end
  end

  brtd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (stage_byte),
    .emit    (emit),
    .token   (token)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_token <= token;
    end
  end

  assign token_kind     = out_token.kind;
  assign int_value      = out_token.int_value;
  assign float_bits     = out_token.float_bits;
  assign use_exponent   = out_token.use_exponent;
  assign decimal_places = out_token.decimal_places;
  assign string_byte    = out_token.string_byte;
  assign last_of_string = out_token.last_of_string;

  // A held byte is never overwritten by a new transfer.
  assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_byte))
    else $error("input register lost a byte");

  // A stalled token is never replaced.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_token))
    else $error("token register overwritten while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_string |-> token_kind == brtd_pkg::KIND_STR_BYTE)
    else $error("end of string marked on a non-string token");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == brtd_pkg::KIND_SINGLE |-> float_bits[63:32] == 32'd0)
    else $error("single float carries upper bits");

endmodule
